// ----- rtl/kdt_pkg.sv -----
// Shared types, constants and lookup functions for the keypad dial timer.
// Used by kdt_core, keypad_dial_timer_controller and kdt_checker.
`default_nettype none

package kdt_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CW_PHASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CCW_PHASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUZZ_PULSE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BUZZ_HIGH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BUZZ_LOW   = 3'd6;

  // configuration reset values
  localparam logic [15:0] RST_CW_PHASE   = 16'd6000;
  localparam logic [15:0] RST_CCW_PHASE  = 16'd53000;
  localparam logic [3:0]  RST_STEPS      = 4'd9;
  localparam logic [6:0]  RST_MAX_COUNT  = 7'd59;
  localparam logic [11:0] RST_BUZZ_PULSE = 12'd2500;
  localparam logic [15:0] RST_BUZZ_HIGH  = 16'd1000;
  localparam logic [15:0] RST_BUZZ_LOW   = 16'd1;

  // mode codes as seen on the mode output
  localparam logic [2:0] MODE_ENTRY = 3'd0;
  localparam logic [2:0] MODE_FWD   = 3'd1;
  localparam logic [2:0] MODE_WAIT  = 3'd2;
  localparam logic [2:0] MODE_BACK  = 3'd3;
  localparam logic [2:0] MODE_BUZZ  = 3'd4;

  localparam logic [7:0] KEY_HASH = 8'h23;
  localparam logic [7:0] KEY_ZERO = 8'h30;

  typedef struct packed {
    logic [15:0] cw_phase_ticks;
    logic [15:0] ccw_phase_ticks;
    logic [3:0]  steps_per_count;
    logic [6:0]  max_count;
    logic [11:0] buzz_pulses;
    logic [15:0] buzz_high_ticks;
    logic [15:0] buzz_low_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0] row_drive;
    logic [3:0] coil_drive;
    logic       buzzer;
    logic [2:0] mode;
    logic       key_valid;
    logic [7:0] key_code;
    logic [6:0] count_value;
  } result_t;

  function automatic logic [3:0] fwd_coil(input logic [1:0] phase);
    case (phase)
      2'd0:    fwd_coil = 4'h9;
      2'd1:    fwd_coil = 4'hA;
      2'd2:    fwd_coil = 4'h6;
      default: fwd_coil = 4'h5;
    endcase
  endfunction

  function automatic logic [3:0] back_coil(input logic [1:0] phase);
    case (phase)
      2'd0:    back_coil = 4'hC;
      2'd1:    back_coil = 4'h6;
      2'd2:    back_coil = 4'h3;
      default: back_coil = 4'h9;
    endcase
  endfunction

  // more or fewer than one low column decodes as column 0
  function automatic logic [1:0] decode_column(input logic [3:0] cols);
    case (cols)
      4'hE:    decode_column = 2'd0;
      4'hD:    decode_column = 2'd1;
      4'hB:    decode_column = 2'd2;
      4'h7:    decode_column = 2'd3;
      default: decode_column = 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] pad_key(input logic [1:0] row, input logic [1:0] col);
    case ({row, col})
      4'd0:    pad_key = "1";
      4'd1:    pad_key = "2";
      4'd2:    pad_key = "3";
      4'd3:    pad_key = "A";
      4'd4:    pad_key = "4";
      4'd5:    pad_key = "5";
      4'd6:    pad_key = "6";
      4'd7:    pad_key = "B";
      4'd8:    pad_key = "7";
      4'd9:    pad_key = "8";
      4'd10:   pad_key = "9";
      4'd11:   pad_key = "C";
      4'd12:   pad_key = "*";
      4'd13:   pad_key = "0";
      4'd14:   pad_key = "#";
      default: pad_key = "D";
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- rtl/kdt_core.sv -----
// Per-tick state machine: keypad scan, count entry, stepper and buzzer timing.
// Depends on kdt_pkg; driven by keypad_dial_timer_controller.
`default_nettype none

module kdt_core
  import kdt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [3:0] column_lines,
  input  wire cfg_t       cfg,
  output result_t         result
);

  typedef enum logic [2:0] {
    ST_ENTRY = MODE_ENTRY,
    ST_FWD   = MODE_FWD,
    ST_WAIT  = MODE_WAIT,
    ST_BACK  = MODE_BACK,
    ST_BUZZ  = MODE_BUZZ
  } state_t;

  state_t      mode_reg, mode_reg_next;
  logic [1:0]  scan_row, scan_row_next;
  logic [3:0]  held_columns, held_columns_next;
  logic        key_pending, key_pending_next;
  logic [7:0]  key_buf0, key_buf0_next;
  logic [7:0]  key_buf1, key_buf1_next;
  logic [1:0]  entry_index, entry_index_next;
  logic [6:0]  count_reg, count_reg_next;
  logic [10:0] cycle_counter, cycle_counter_next;
  logic [1:0]  phase_index, phase_index_next;
  logic [15:0] delay_counter, delay_counter_next;
  logic [11:0] pulse_counter, pulse_counter_next;
  logic [3:0]  coil_reg, coil_reg_next;

  logic        kv;
  logic [7:0]  kc;
  logic [10:0] total_cycles;
  logic [15:0] tick_limit;
  logic        delay_hit;
  logic [10:0] cycle_inc;
  logic [11:0] pulse_inc;
  logic        motion_done;
  logic [7:0]  digit0, digit1, raw_count;
  logic [6:0]  clamped;
  logic        steps_zero;

  assign total_cycles = {4'b0, count_reg} * {7'b0, cfg.steps_per_count};
  assign steps_zero   = (cfg.steps_per_count == 4'd0);

  always_comb begin
    case (mode_reg)
      ST_FWD:  tick_limit = cfg.cw_phase_ticks;
      ST_BACK: tick_limit = cfg.ccw_phase_ticks;
      default: tick_limit = (phase_index == 2'd0) ? cfg.buzz_high_ticks : cfg.buzz_low_ticks;
    endcase
  end

  // a zero tick count behaves as one
  assign delay_hit   = ({1'b0, delay_counter} + 17'd1) >= {1'b0, tick_limit};
  assign cycle_inc   = cycle_counter + 11'd1;
  assign pulse_inc   = pulse_counter + 12'd1;
  assign motion_done = (phase_index == 2'd3) && (cycle_inc >= total_cycles);

  // count arithmetic is modulo 256
  assign digit0    = key_buf0 - KEY_ZERO;
  assign digit1    = key_buf1 - KEY_ZERO;
  assign raw_count = (entry_index == 2'd1) ? digit0 : (digit0 * 8'd10) + digit1;
  assign clamped   = (raw_count > {1'b0, cfg.max_count}) ? cfg.max_count : raw_count[6:0];

  always_comb begin
    mode_reg_next      = mode_reg;
    scan_row_next      = scan_row;
    held_columns_next  = held_columns;
    key_pending_next   = key_pending;
    key_buf0_next      = key_buf0;
    key_buf1_next      = key_buf1;
    entry_index_next   = entry_index;
    count_reg_next     = count_reg;
    cycle_counter_next = cycle_counter;
    phase_index_next   = phase_index;
    delay_counter_next = delay_counter;
    pulse_counter_next = pulse_counter;
    coil_reg_next      = coil_reg;
    kv                 = 1'b0;
    kc                 = 8'd0;

    case (mode_reg)
      ST_ENTRY, ST_WAIT: begin
        if (key_pending) begin
          if (column_lines == 4'hF) begin
            kv               = 1'b1;
            kc               = pad_key(scan_row, decode_column(held_columns));
            key_pending_next = 1'b0;
            scan_row_next    = scan_row + 2'd1;
          end
        end else if (column_lines != 4'hF) begin
          held_columns_next = column_lines;
          key_pending_next  = 1'b1;
        end else begin
          scan_row_next = scan_row + 2'd1;
        end

        if (kv && mode_reg == ST_ENTRY) begin
          if (entry_index == 2'd0) begin
            key_buf0_next    = kc;
            entry_index_next = 2'd1;
          end else if (entry_index == 2'd1 && kc != KEY_HASH) begin
            key_buf1_next    = kc;
            entry_index_next = 2'd2;
          end else if (kc == KEY_HASH) begin
            count_reg_next     = clamped;
            key_buf0_next      = KEY_ZERO;
            key_buf1_next      = KEY_ZERO;
            entry_index_next   = 2'd0;
            cycle_counter_next = 11'd0;
            phase_index_next   = 2'd0;
            delay_counter_next = 16'd0;
            mode_reg_next      = (clamped == 7'd0 || steps_zero) ? ST_WAIT : ST_FWD;
          end else begin
            // third key that is not '#': drop it and restart the entry
            key_buf0_next    = KEY_ZERO;
            key_buf1_next    = KEY_ZERO;
            entry_index_next = 2'd0;
          end
        end else if (kv && kc == KEY_HASH) begin
          cycle_counter_next = 11'd0;
          phase_index_next   = 2'd0;
          delay_counter_next = 16'd0;
          if (count_reg == 7'd0 || steps_zero) begin
            key_buf0_next      = KEY_ZERO;
            key_buf1_next      = KEY_ZERO;
            entry_index_next   = 2'd0;
            pulse_counter_next = 12'd0;
            mode_reg_next      = (cfg.buzz_pulses == 12'd0) ? ST_ENTRY : ST_BUZZ;
          end else begin
            mode_reg_next = ST_BACK;
          end
        end
      end

      ST_FWD, ST_BACK: begin
        if (delay_hit) begin
          delay_counter_next = 16'd0;
          coil_reg_next      = (mode_reg == ST_FWD) ? fwd_coil(phase_index)
                                                    : back_coil(phase_index);
          phase_index_next   = phase_index + 2'd1;
          if (phase_index == 2'd3) begin
            cycle_counter_next = cycle_inc;
          end
          if (motion_done) begin
            if (mode_reg == ST_FWD) begin
              mode_reg_next = ST_WAIT;
            end else begin
              key_buf0_next      = KEY_ZERO;
              key_buf1_next      = KEY_ZERO;
              entry_index_next   = 2'd0;
              pulse_counter_next = 12'd0;
              mode_reg_next      = (cfg.buzz_pulses == 12'd0) ? ST_ENTRY : ST_BUZZ;
            end
          end
        end else begin
          delay_counter_next = delay_counter + 16'd1;
        end
      end

      ST_BUZZ: begin
        if (delay_hit) begin
          delay_counter_next = 16'd0;
          if (phase_index == 2'd0) begin
            phase_index_next = 2'd1;
          end else begin
            phase_index_next   = 2'd0;
            pulse_counter_next = pulse_inc;
            if (pulse_inc >= cfg.buzz_pulses) begin
              mode_reg_next = ST_ENTRY;
            end
          end
        end else begin
          delay_counter_next = delay_counter + 16'd1;
        end
      end

      default: begin
        mode_reg_next = ST_ENTRY;
      end
    endcase
  end

  always_comb begin
    result.row_drive   = ~(4'b0001 << scan_row);
    result.coil_drive  = coil_reg_next;
    result.buzzer      = (mode_reg_next == ST_BUZZ) && (phase_index_next == 2'd0);
    result.mode        = mode_reg_next;
    result.key_valid   = kv;
    result.key_code    = kc;
    result.count_value = count_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= ST_ENTRY;
      scan_row      <= 2'd0;
      held_columns  <= 4'hF;
      key_pending   <= 1'b0;
      entry_index   <= 2'd0;
      count_reg     <= 7'd0;
      cycle_counter <= 11'd0;
      phase_index   <= 2'd0;
      delay_counter <= 16'd0;
      pulse_counter <= 12'd0;
      coil_reg      <= 4'd0;
    end else if (step) begin
      mode_reg      <= mode_reg_next;
      scan_row      <= scan_row_next;
      held_columns  <= held_columns_next;
      key_pending   <= key_pending_next;
      entry_index   <= entry_index_next;
      count_reg     <= count_reg_next;
      cycle_counter <= cycle_counter_next;
      phase_index   <= phase_index_next;
      delay_counter <= delay_counter_next;
      pulse_counter <= pulse_counter_next;
      coil_reg      <= coil_reg_next;
    end
  end

  // entry digits are always written before they are read
  always_ff @(posedge clk) begin
    if (step) begin
      key_buf0 <= key_buf0_next;
      key_buf1 <= key_buf1_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/keypad_dial_timer_controller.sv -----
// Top level: configuration registers, input handshake and output register.
// Depends on kdt_pkg and kdt_core.
`default_nettype none

// One transaction per tick: each accepted column sample advances the keypad
// scan, entry, stepper and buzzer state by one tick and produces exactly one
// result in the next cycle. A new sample is taken every clock while the result
// register is free or being drained; the only stall comes from out_stall
// holding an unread result. Throughput is one per clock when not stalled; the
// single result register after the next-state logic holds each result.

module keypad_dial_timer_controller
  import kdt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [3:0]            column_lines,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [3:0]                 row_drive,
  output logic [3:0]                 coil_drive,
  output logic                       buzzer,
  output logic [2:0]                 mode,
  output logic                       key_valid,
  output logic [7:0]                 key_code,
  output logic [6:0]                 count_value,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  result_t result;
  logic    accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cw_phase_ticks  <= RST_CW_PHASE;
      cfg.ccw_phase_ticks <= RST_CCW_PHASE;
      cfg.steps_per_count <= RST_STEPS;
      cfg.max_count       <= RST_MAX_COUNT;
      cfg.buzz_pulses     <= RST_BUZZ_PULSE;
      cfg.buzz_high_ticks <= RST_BUZZ_HIGH;
      cfg.buzz_low_ticks  <= RST_BUZZ_LOW;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CW_PHASE:   cfg.cw_phase_ticks  <= cfg_data;
        CFG_CCW_PHASE:  cfg.ccw_phase_ticks <= cfg_data;
        CFG_STEPS:      cfg.steps_per_count <= cfg_data[3:0];
        CFG_MAX_COUNT:  cfg.max_count       <= cfg_data[6:0];
        CFG_BUZZ_PULSE: cfg.buzz_pulses     <= cfg_data[11:0];
        CFG_BUZZ_HIGH:  cfg.buzz_high_ticks <= cfg_data;
        CFG_BUZZ_LOW:   cfg.buzz_low_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  kdt_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (accept),
    .column_lines (column_lines),
    .cfg          (cfg),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_drive   <= result.row_drive;
      coil_drive  <= result.coil_drive;
      buzzer      <= result.buzzer;
      mode        <= result.mode;
      key_valid   <= result.key_valid;
      key_code    <= result.key_code;
      count_value <= result.count_value;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kdt_checker.sv -----
// Port-level assertions for keypad_dial_timer_controller, bound to the top level.
// Depends on kdt_pkg.
`default_nettype none

module kdt_checker
  import kdt_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [3:0] coil_drive,
  input wire logic       buzzer,
  input wire logic [2:0] mode,
  input wire logic       key_valid,
  input wire logic [7:0] key_code,
  input wire logic [6:0] count_value
);

  // a stalled transaction stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mode) && $stable(key_code)
      && $stable(coil_drive) && $stable(count_value))
    else $error("stalled result changed");

  // every accepted sample yields a result on the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted sample produced no result");

  a_key_code_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_valid |-> key_code == 8'd0)
    else $error("key code without key");

  a_buzz_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && buzzer |-> mode == MODE_BUZZ)
    else $error("buzzer high outside buzzing mode");

endmodule

bind keypad_dial_timer_controller kdt_checker u_kdt_checker (.*);

`default_nettype wire

// ----- test/tb_keypad_dial_timer_controller.sv -----
// Self-checking testbench for keypad_dial_timer_controller: keypad key entry, stepper runs
// and buzzer pulses, checked against an in-bench tick model of the controller.
// Depends on kdt_pkg and the controller RTL.

module tb_keypad_dial_timer_controller;
  import kdt_pkg::*;

  typedef struct packed {
    logic [2:0]       mode;
    logic [1:0]       row;
    logic [3:0]       held;
    logic             pending;
    logic [1:0][7:0]  keys;
    logic [1:0]       entry_len;
    logic [6:0]       count;
    logic [10:0]      cycles;
    logic [1:0]       phase;
    logic [15:0]      delay;
    logic [11:0]      pulses;
    logic [3:0]       coil;
  } dial_state_t;

  localparam logic [3:0] FWD_PATTERN [4] = '{4'h9, 4'hA, 4'h6, 4'h5};
  localparam logic [3:0] BACK_PATTERN [4] = '{4'hC, 4'h6, 4'h3, 4'h9};
  localparam logic [7:0] PAD_KEYS [16] = '{"1", "2", "3", "A", "4", "5", "6", "B",
                                           "7", "8", "9", "C", "*", "0", "#", "D"};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] column_lines = 4'hF;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] row_drive;
  logic [3:0] coil_drive;
  logic buzzer;
  logic [2:0] mode;
  logic key_valid;
  logic [7:0] key_code;
  logic [6:0] count_value;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CW_PHASE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  keypad_dial_timer_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .column_lines(column_lines),
    .out_valid(out_valid), .out_stall(out_stall),
    .row_drive(row_drive), .coil_drive(coil_drive), .buzzer(buzzer), .mode(mode),
    .key_valid(key_valid), .key_code(key_code), .count_value(count_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cfg_t dial_cfg;
  dial_state_t dial_live;
  dial_state_t dial_plan;
  logic [3:0] pending_columns [$];
  result_t expected_results [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int results_checked = 0;

  logic col_taken = 1'b0;
  logic result_taken = 1'b0;
  logic [3:0] taken_cols;
  result_t seen;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb_keypad_dial_timer_controller failed");
    $finish;
  end

  function automatic int unsigned run_cycles(input dial_state_t s, input cfg_t c);
    return 32'(s.count) * 32'(c.steps_per_count);
  endfunction

  function automatic void clear_keys(inout dial_state_t s);
    s.keys = {KEY_ZERO, KEY_ZERO};
    s.entry_len = 2'd0;
  endfunction

  function automatic void begin_buzz(inout dial_state_t s, input cfg_t c);
    s.mode = MODE_BUZZ;
    s.pulses = '0;
    s.phase = 2'd0;
    s.delay = '0;
    if (c.buzz_pulses == 0) s.mode = MODE_ENTRY;
  endfunction

  // one stepper tick; true once the last four-phase cycle has completed
  function automatic bit motor_step(inout dial_state_t s, input cfg_t c, input bit reverse);
    logic [15:0] ticks;
    ticks = reverse ? c.ccw_phase_ticks : c.cw_phase_ticks;
    if (32'(s.delay) + 32'd1 >= 32'(ticks)) begin
      s.delay = '0;
      s.coil = reverse ? BACK_PATTERN[s.phase] : FWD_PATTERN[s.phase];
      s.phase = s.phase + 2'd1;
      if (s.phase == 2'd0) begin
        s.cycles = s.cycles + 11'd1;
        return 32'(s.cycles) >= run_cycles(s, c);
      end
    end else begin
      s.delay = s.delay + 16'd1;
    end
    return 1'b0;
  endfunction

  function automatic result_t dial_tick(inout dial_state_t s, input cfg_t c,
                                        input logic [3:0] cols);
    result_t r;
    logic [1:0] col;
    logic [7:0] raw;
    logic [15:0] lim;
    r = '0;
    r.row_drive = ~(4'b0001 << s.row);
    if (s.mode == MODE_ENTRY || s.mode == MODE_WAIT) begin
      if (s.pending) begin
        if (cols == 4'hF) begin
          case (s.held)
            4'hD: col = 2'd1;
            4'hB: col = 2'd2;
            4'h7: col = 2'd3;
            default: col = 2'd0;
          endcase
          r.key_valid = 1'b1;
          r.key_code = PAD_KEYS[{s.row, col}];
          s.pending = 1'b0;
          s.row = s.row + 2'd1;
        end
      end else if (cols != 4'hF) begin
        s.held = cols;
        s.pending = 1'b1;
      end else begin
        s.row = s.row + 2'd1;
      end
      if (r.key_valid && s.mode == MODE_ENTRY) begin
        if (s.entry_len == 2'd0) begin
          s.keys[0] = r.key_code;
          s.entry_len = 2'd1;
        end else if (r.key_code == KEY_HASH) begin
          if (s.entry_len == 2'd1) raw = s.keys[0] - KEY_ZERO;
          else raw = (s.keys[0] - KEY_ZERO) * 8'd10 + (s.keys[1] - KEY_ZERO);
          s.count = (raw > 8'(c.max_count)) ? c.max_count : raw[6:0];
          clear_keys(s);
          s.mode = MODE_FWD;
          s.cycles = '0;
          s.phase = 2'd0;
          s.delay = '0;
          if (run_cycles(s, c) == 0) s.mode = MODE_WAIT;
        end else if (s.entry_len == 2'd1) begin
          s.keys[1] = r.key_code;
          s.entry_len = 2'd2;
        end else begin
          clear_keys(s);
        end
      end else if (r.key_valid && r.key_code == KEY_HASH) begin
        s.mode = MODE_BACK;
        s.cycles = '0;
        s.phase = 2'd0;
        s.delay = '0;
        if (run_cycles(s, c) == 0) begin
          clear_keys(s);
          begin_buzz(s, c);
        end
      end
    end else if (s.mode == MODE_FWD) begin
      if (motor_step(s, c, 1'b0)) s.mode = MODE_WAIT;
    end else if (s.mode == MODE_BACK) begin
      if (motor_step(s, c, 1'b1)) begin
        clear_keys(s);
        begin_buzz(s, c);
      end
    end else if (s.mode == MODE_BUZZ) begin
      lim = (s.phase == 2'd0) ? c.buzz_high_ticks : c.buzz_low_ticks;
      if (32'(s.delay) + 32'd1 >= 32'(lim)) begin
        s.delay = '0;
        if (s.phase == 2'd0) begin
          s.phase = 2'd1;
        end else begin
          s.phase = 2'd0;
          s.pulses = s.pulses + 12'd1;
          if (s.pulses >= c.buzz_pulses) s.mode = MODE_ENTRY;
        end
      end else begin
        s.delay = s.delay + 16'd1;
      end
    end else begin
      s.mode = MODE_ENTRY;
    end
    r.coil_drive = s.coil;
    r.buzzer = (s.mode == MODE_BUZZ) && (s.phase == 2'd0);
    r.mode = s.mode;
    r.count_value = s.count;
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("row %h coil %h buzz %b mode %0d key %b/%h count %0d", r.row_drive,
                     r.coil_drive, r.buzzer, r.mode, r.key_valid, r.key_code, r.count_value);
  endfunction

  // ---------------- stimulus planning ----------------

  task automatic queue_columns(input logic [3:0] cols);
    pending_columns.push_back(cols);
    void'(dial_tick(dial_plan, dial_cfg, cols));
  endtask

  function automatic bit plan_scanning();
    return dial_plan.mode == MODE_ENTRY || dial_plan.mode == MODE_WAIT;
  endfunction

  // wait for the wanted row, press for hold ticks, then release
  task automatic press_key(input logic [1:0] row, input logic [3:0] pattern, input int hold);
    while (plan_scanning() && (dial_plan.pending || dial_plan.row != row))
      queue_columns(4'hF);
    if (!plan_scanning()) return;
    queue_columns(pattern);
    repeat (hold - 1) queue_columns(4'($urandom_range(14)));
    queue_columns(4'hF);
  endtask

  task automatic press_char(input logic [7:0] key);
    int idx;
    logic [3:0] pattern;
    idx = 0;
    for (int i = 0; i < 16; i++)
      if (PAD_KEYS[i] == key) idx = i;
    pattern = ~(4'b0001 << idx[1:0]);
    // column 0 also answers to patterns with several low lines
    if (idx[1:0] == 2'd0 && $urandom_range(3) == 0) begin
      do pattern = 4'($urandom_range(14));
      while (pattern == 4'hE || pattern == 4'hD || pattern == 4'hB || pattern == 4'h7);
    end
    press_key(idx[3:2], pattern, $urandom_range(1, 3));
  endtask

  function automatic logic [7:0] count_key();
    if ($urandom_range(6) == 0) return PAD_KEYS[$urandom_range(15)];
    return KEY_ZERO + 8'($urandom_range(9));
  endfunction

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) queue_columns(4'($urandom_range(15)));
  endtask

  task automatic fill_random(input int n);
    int target;
    int pick;
    logic [7:0] extra;
    target = pending_columns.size() + n;
    while (pending_columns.size() < target) begin
      pick = $urandom_range(99);
      case (dial_plan.mode)
        MODE_ENTRY: begin
          if (pick < 70) begin
            press_char(count_key());
            if ($urandom_range(2) != 0) press_char(count_key());
            if ($urandom_range(9) == 0) begin
              do extra = PAD_KEYS[$urandom_range(15)];
              while (extra == KEY_HASH);
              press_char(extra);
            end
            press_char(KEY_HASH);
          end else if (pick < 85) begin
            send_noise();
          end else begin
            press_char(PAD_KEYS[$urandom_range(15)]);
          end
        end
        MODE_WAIT: begin
          if (pick < 75) press_char(KEY_HASH);
          else if (pick < 90) press_char(PAD_KEYS[$urandom_range(15)]);
          else send_noise();
        end
        default: send_noise();
      endcase
    end
  endtask

  function automatic cfg_t small_cfg();
    cfg_t c;
    c.cw_phase_ticks = 16'($urandom_range(1, 3));
    c.ccw_phase_ticks = 16'($urandom_range(1, 3));
    c.steps_per_count = 4'($urandom_range(1, 2));
    c.max_count = 7'($urandom_range(0, 6));
    c.buzz_pulses = 12'($urandom_range(0, 3));
    c.buzz_high_ticks = 16'($urandom_range(1, 3));
    c.buzz_low_ticks = 16'($urandom_range(1, 3));
    return c;
  endfunction

  // ---------------- configuration and phases ----------------

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_columns.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  task automatic program_regs(input cfg_t c);
    write_reg(CFG_CW_PHASE, c.cw_phase_ticks);
    write_reg(CFG_CCW_PHASE, c.ccw_phase_ticks);
    write_reg(CFG_STEPS, 16'(c.steps_per_count));
    write_reg(CFG_MAX_COUNT, 16'(c.max_count));
    write_reg(CFG_BUZZ_PULSE, 16'(c.buzz_pulses));
    write_reg(CFG_BUZZ_HIGH, c.buzz_high_ticks);
    write_reg(CFG_BUZZ_LOW, c.buzz_low_ticks);
    @(posedge clk);
    cfg_write <= 1'b0;
    dial_cfg = c;
  endtask

  task automatic run_phase(input cfg_t c, input int idle_pct, input int stall_pct,
                           input int n);
    wait_idle();
    program_regs(c);
    @(negedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    fill_random(n);
  endtask

  // ---------------- driver, receiver, checker ----------------

  always @(negedge clk) begin
    col_taken = in_valid && !in_stall;
    result_taken = out_valid && !out_stall;
    taken_cols = column_lines;
    seen = {row_drive, coil_drive, buzzer, mode, key_valid, key_code, count_value};
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || col_taken) begin
      if (pending_columns.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        column_lines <= pending_columns.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    string bad;
    if (!rst) begin
      if (result_taken) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %s", show(seen));
        end else begin
          want = expected_results.pop_front();
          bad = "";
          if (seen.row_drive !== want.row_drive) bad = {bad, " row_drive"};
          if (seen.coil_drive !== want.coil_drive) bad = {bad, " coil_drive"};
          if (seen.buzzer !== want.buzzer) bad = {bad, " buzzer"};
          if (seen.mode !== want.mode) bad = {bad, " mode"};
          if (seen.key_valid !== want.key_valid) bad = {bad, " key_valid"};
          if (seen.key_code !== want.key_code) bad = {bad, " key_code"};
          if (seen.count_value !== want.count_value) bad = {bad, " count_value"};
          if (bad != "") begin
            mismatches++;
            if (mismatches <= 10)
              $display("transaction %0d mismatch in%s\n  expected %s\n  actual   %s",
                       results_checked, bad, show(want), show(seen));
          end
        end
      end
      if (col_taken) expected_results.push_back(dial_tick(dial_live, dial_cfg, taken_cols));
    end
  end

  // ---------------- test sequence ----------------

  initial begin
    cfg_t c;
    dial_cfg = '{cw_phase_ticks: RST_CW_PHASE, ccw_phase_ticks: RST_CCW_PHASE,
                 steps_per_count: RST_STEPS, max_count: RST_MAX_COUNT,
                 buzz_pulses: RST_BUZZ_PULSE, buzz_high_ticks: RST_BUZZ_HIGH,
                 buzz_low_ticks: RST_BUZZ_LOW};
    dial_live = '0;
    dial_live.mode = MODE_ENTRY;
    dial_live.held = 4'hF;
    dial_plan = dial_live;

    // reset values: hash as first key, all columns low, third key clears
    press_key(2'd3, 4'hB, 1);
    press_key(2'd1, 4'h0, 2);
    press_key(2'd2, 4'h7, 3);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // zero clamp skips both runs, no pulses skips buzzing; non-digit count
    wait_idle();
    program_regs('{cw_phase_ticks: 16'd1, ccw_phase_ticks: 16'd1, steps_per_count: 4'd1,
                   max_count: 7'd0, buzz_pulses: 12'd0, buzz_high_ticks: 16'd1,
                   buzz_low_ticks: 16'd1});
    @(negedge clk);
    press_char(KEY_HASH);
    press_char("A");
    press_char(KEY_HASH);
    press_char("A");
    press_char(KEY_HASH);

    run_phase(small_cfg(), 0, 0, 250);
    run_phase(small_cfg(), 88, 0, 200);
    c = '{cw_phase_ticks: 16'hFFFF, ccw_phase_ticks: 16'hFFFF, steps_per_count: 4'd15,
          max_count: 7'd99, buzz_pulses: 12'hFFF, buzz_high_ticks: 16'hFFFF,
          buzz_low_ticks: 16'hFFFF};
    run_phase(c, 28, 28, 60);
    // zero tick counts act as one; zero steps ends a run in progress when its current four-phase cycle completes
    c = '{cw_phase_ticks: 16'd0, ccw_phase_ticks: 16'd0, steps_per_count: 4'd0,
          max_count: 7'd7, buzz_pulses: 12'd2, buzz_high_ticks: 16'd0,
          buzz_low_ticks: 16'd0};
    run_phase(c, 0, 88, 150);
    run_phase(small_cfg(), 0, 88, 200);
    run_phase(small_cfg(), 28, 28, 200);
    run_phase(small_cfg(), 0, 0, 200);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_keypad_dial_timer_controller passed");
    end else begin
      $display("tb_keypad_dial_timer_controller failed");
    end
    $finish;
  end

endmodule
